// ----- src/double_ended_stack_allocator_unit_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the double-ended stack allocator unit
// Shared assertion forms that are clocked on clk and disabled during rst.
// ----------------------------------------------------------------------------
`ifndef DOUBLE_ENDED_STACK_ALLOCATOR_UNIT_MACROS_SVH
`define DOUBLE_ENDED_STACK_ALLOCATOR_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DSA_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DSA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/dsa_pkg.sv -----
// ----------------------------------------------------------------------------
// Double-ended stack allocator package
// Transaction types, codes and sizing constants shared by the allocator files.
// ----------------------------------------------------------------------------
package dsa_pkg;

  localparam int unsigned MAX_CAPACITY_DEF = 65536;
  localparam int unsigned HEADER_BYTES = 16;
  localparam int unsigned MIN_ALIGN = 8;

  localparam int unsigned CUR_W = 17;
  localparam int unsigned PAD_W = 20;
  localparam int unsigned CUR_MAX = (1 << CUR_W) - 1;

  localparam logic SIDE_FRONT = 1'b0;
  localparam logic SIDE_BACK = 1'b1;

  typedef enum logic [1:0] {
    OP_ALLOC,
    OP_FREE,
    OP_RESET,
    OP_RESTORE
  } op_t;

  typedef enum logic [2:0] {
    ST_OK,
    ST_NO_SPACE,
    ST_BAD_STATE,
    ST_FREE_IGNORED,
    ST_ZERO_BACK
  } status_t;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } fsm_state_t;

  typedef struct packed {
    op_t              op;
    logic             side;
    logic [16:0]      size;
    logic [3:0]       align_log2;
    logic [15:0]      addr;
    logic [16:0]      mark_front;
    logic [16:0]      mark_back;
  } in_item_t;

  typedef struct packed {
    status_t          status;
    logic [16:0]      data_offset;
    logic [16:0]      front_offset;
    logic [16:0]      back_offset;
    logic [16:0]      bytes_free;
  } out_item_t;

  typedef struct packed {
    logic [CUR_W-1:0] prev;
    logic [CUR_W-1:0] size;
  } hdr_t;

  typedef struct packed {
    logic [CUR_W-1:0] front;
    logic [CUR_W-1:0] back;
  } cursor_pair_t;

endpackage

// ----- src/double_ended_stack_allocator_unit.sv -----
// ----------------------------------------------------------------------------
// Double-ended stack allocator unit
// Front and back stack cursors over one byte region, with block headers kept
// in a header memory.
// ----------------------------------------------------------------------------
// The in channel carries one request per transaction: allocate, free the last
// block of a side, reset both cursors, or restore a saved cursor pair. Each
// request gives exactly one response on the out channel with a status, the
// aligned data offset and both cursors after the request.
// The cfg channel writes the region capacity; it is always ready and should
// only be written while no request is outstanding.
// The accept cycle reads the header memory and works out the alignment pad;
// the S_EXEC state then updates the cursors, writes the header of a new block
// and loads the output register, waiting while that register holds a response.
// The response is valid once it is loaded, and the unit accepts no new request
// until the update of the last one is done.
// After reset the header memory is cleared one entry per cycle, over all
// MAX_CAPACITY / 8 entries (8192 by default); in_ready stays low meanwhile.
// When out_ready is low, one response waits in the output register and one
// more request may be accepted; that request then holds until the register
// drains.
// ----------------------------------------------------------------------------
`include "double_ended_stack_allocator_unit_macros.svh"

module double_ended_stack_allocator_unit import dsa_pkg::*; #(
  parameter int unsigned MAX_CAPACITY = MAX_CAPACITY_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [16:0] cfg_data
);

  localparam int unsigned DEPTH = MAX_CAPACITY / 8;
  localparam int unsigned SLOT_W = $clog2(DEPTH);
  localparam logic [CUR_W-1:0] CAP_RESET =
    (MAX_CAPACITY > CUR_MAX) ? CUR_W'(CUR_MAX) : CUR_W'(MAX_CAPACITY);

  fsm_state_t        state;
  fsm_state_t        state_next;
  logic [CUR_W-1:0]  capacity;
  logic [CUR_W-1:0]  cap_lim;
  logic [CUR_W-1:0]  front_cursor;
  logic [CUR_W-1:0]  back_cursor;
  logic              exec_done;
  logic              clearing;
  logic              accept;
  logic [31:0]       addr_ext;
  hdr_t              rd_hdr;
  out_item_t         result;
  cursor_pair_t      cur_next;
  logic              hdr_we_req;
  logic              hdr_we;
  logic [SLOT_W-1:0] hdr_wr_slot;
  hdr_t              hdr_wr_data;

  assign cfg_ready = 1'b1;
  assign cap_lim = (32'(capacity) > MAX_CAPACITY) ? CUR_W'(MAX_CAPACITY) : capacity;
  assign accept = in_valid && in_ready;
  assign addr_ext = 32'(in_data.addr);
  assign hdr_we = hdr_we_req && exec_done;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (exec_done) begin
          state_next = S_IDLE;
        end
      end
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    exec_done = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = !clearing;
      end
      S_EXEC: begin
        exec_done = !out_valid || out_ready;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      capacity <= CAP_RESET;
      front_cursor <= '0;
      back_cursor <= CAP_RESET;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        capacity <= cfg_data;
      end
      if (exec_done) begin
        front_cursor <= cur_next.front;
        back_cursor <= cur_next.back;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (exec_done) begin
      out_data <= result;
    end
  end

  dsa_hdr_mem #(
    .DEPTH (DEPTH),
    .AW    (SLOT_W)
  ) u_hdr_mem (
    .clk      (clk),
    .rst      (rst),
    .rd_en    (accept),
    .rd_addr  (addr_ext[SLOT_W+2:3]),
    .rd_data  (rd_hdr),
    .wr_en    (hdr_we),
    .wr_addr  (hdr_wr_slot),
    .wr_data  (hdr_wr_data),
    .clearing (clearing)
  );

  dsa_core #(
    .SLOT_W (SLOT_W)
  ) u_core (
    .clk         (clk),
    .load        (accept),
    .item        (in_data),
    .front       (front_cursor),
    .back        (back_cursor),
    .cap_lim     (cap_lim),
    .rd_hdr      (rd_hdr),
    .result      (result),
    .cur_next    (cur_next),
    .hdr_we_req  (hdr_we_req),
    .hdr_wr_slot (hdr_wr_slot),
    .hdr_wr_data (hdr_wr_data)
  );

  `DSA_ASSERT_NEXT(a_done_gives_response, exec_done, out_valid,
                   "A finished transaction did not load the output register.")
  `DSA_ASSERT_NEXT(a_cursors_hold, !exec_done,
                   $stable(front_cursor) && $stable(back_cursor),
                   "A cursor moved outside the update cycle.")
  `DSA_ASSERT_SAME(a_header_write_in_exec, hdr_we, state == S_EXEC && !clearing,
                   "Header write issued outside the update cycle.")
  `DSA_ASSERT_NEXT(a_accept_enters_exec, accept, state == S_EXEC,
                   "An accepted transaction did not start its update cycle.")

endmodule

// ----- src/dsa_hdr_mem.sv -----
// ----------------------------------------------------------------------------
// Header memory
// One-write, one-read synchronous memory of block headers with a registered
// read port and a zeroing sweep over every entry after reset.
// ----------------------------------------------------------------------------
`include "double_ended_stack_allocator_unit_macros.svh"

module dsa_hdr_mem import dsa_pkg::*; #(
  parameter int unsigned DEPTH = MAX_CAPACITY_DEF / 8,
  parameter int unsigned AW = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output hdr_t          rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  hdr_t          wr_data,
  output logic          clearing
);

  hdr_t          mem [DEPTH];
  logic          clr_busy;
  logic [AW-1:0] clr_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_busy <= 1'b1;
      clr_addr <= '0;
    end else if (clr_busy) begin
      if (clr_addr == AW'(DEPTH - 1)) begin
        clr_busy <= 1'b0;
      end
      clr_addr <= clr_addr + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (clr_busy) begin
      mem[clr_addr] <= '0;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  assign clearing = clr_busy;

  `DSA_ASSERT_SAME(a_no_write_in_sweep, wr_en, !clr_busy,
                   "Header write collided with the clearing sweep.")
  `DSA_ASSERT_SAME(a_no_read_in_sweep, rd_en, !clr_busy,
                   "Header read issued during the clearing sweep.")

endmodule

// ----- src/dsa_core.sv -----
// ----------------------------------------------------------------------------
// Allocator datapath
// Registers the accepted transaction with its alignment pad, then evaluates
// allocation, free, reset and restore against the cursors and stored header.
// ----------------------------------------------------------------------------
module dsa_core import dsa_pkg::*; #(
  parameter int unsigned SLOT_W = 13
) (
  input  logic              clk,
  input  logic              load,
  input  in_item_t          item,
  input  logic [CUR_W-1:0]  front,
  input  logic [CUR_W-1:0]  back,
  input  logic [CUR_W-1:0]  cap_lim,
  input  hdr_t              rd_hdr,
  output out_item_t         result,
  output cursor_pair_t      cur_next,
  output logic              hdr_we_req,
  output logic [SLOT_W-1:0] hdr_wr_slot,
  output hdr_t              hdr_wr_data
);

  in_item_t         item_q;
  logic [PAD_W-1:0] pad_q;
  logic             ok_q;

  logic [PAD_W-1:0] align_raw;
  logic [PAD_W-1:0] align_v;
  logic [PAD_W-1:0] amask;
  logic [PAD_W-1:0] cur_w;
  logic [PAD_W-1:0] mis;
  logic [PAD_W-1:0] pad0;
  logic [PAD_W-1:0] payload;
  logic [PAD_W-1:0] gap;
  logic [PAD_W-1:0] pad_c;
  logic             ok_now;

  always_comb begin
    align_raw = PAD_W'(1) << item.align_log2;
    align_v = (align_raw < PAD_W'(MIN_ALIGN)) ? PAD_W'(MIN_ALIGN) : align_raw;
    amask = align_v - PAD_W'(1);
    cur_w = (item.side == SIDE_BACK) ? PAD_W'(back) : PAD_W'(front);
    mis = cur_w & amask;
    if (mis == '0) begin
      pad0 = '0;
    end else if (item.side == SIDE_BACK) begin
      pad0 = mis;
    end else begin
      pad0 = align_v - mis;
    end
    payload = (item.side == SIDE_BACK) ? PAD_W'(item.size) : PAD_W'(HEADER_BYTES);
    gap = payload - pad0 + amask;
    pad_c = (pad0 < payload) ? (pad0 + (gap & ~amask)) : pad0;
    ok_now = (front <= cap_lim) && (back <= cap_lim) && (front <= back);
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_q <= item;
      pad_q <= pad_c;
      ok_q <= ok_now;
    end
  end

  logic [PAD_W-1:0] f_w;
  logic [PAD_W-1:0] b_w;
  logic [PAD_W-1:0] need;
  logic [PAD_W-1:0] d_w;
  logic [CUR_W-1:0] d;
  logic [31:0]      d_ext;
  logic [CUR_W-1:0] a17;
  logic             free_ok;
  logic             free_match;
  logic             is_back;
  status_t          status;
  logic [CUR_W-1:0] data_off;
  logic [CUR_W-1:0] nf;
  logic [CUR_W-1:0] nb;
  logic             ok_new;

  always_comb begin
    is_back = (item_q.side == SIDE_BACK);
    f_w = PAD_W'(front);
    b_w = PAD_W'(back);
    need = f_w + pad_q + (is_back ? PAD_W'(HEADER_BYTES) : PAD_W'(item_q.size));
    d_w = is_back ? (b_w - pad_q) : (f_w + pad_q);
    d = d_w[CUR_W-1:0];
    d_ext = 32'(d);
    a17 = CUR_W'(item_q.addr);
    free_ok = (a17 >= CUR_W'(HEADER_BYTES)) && (a17 < cap_lim) &&
              (is_back ? (a17 >= back) : (a17 < front));
    free_match = is_back ? ((a17 - CUR_W'(HEADER_BYTES)) == back) :
                           ((PAD_W'(a17) + PAD_W'(rd_hdr.size)) == f_w);

    status = ST_OK;
    data_off = '0;
    nf = front;
    nb = back;
    hdr_we_req = 1'b0;
    unique case (item_q.op)
      OP_RESET: begin
        nf = '0;
        nb = cap_lim;
      end
      OP_ALLOC: begin
        if (!ok_q) begin
          status = ST_BAD_STATE;
        end else if (is_back && item_q.size == '0) begin
          status = ST_ZERO_BACK;
        end else if (!(need < b_w)) begin
          status = ST_NO_SPACE;
        end else begin
          hdr_we_req = 1'b1;
          data_off = d;
          if (is_back) begin
            nb = CUR_W'(d_w - PAD_W'(HEADER_BYTES));
          end else begin
            nf = CUR_W'(d_w + PAD_W'(item_q.size));
          end
        end
      end
      OP_FREE: begin
        if (!ok_q) begin
          status = ST_BAD_STATE;
        end else if (!(free_ok && free_match)) begin
          status = ST_FREE_IGNORED;
        end else if (is_back) begin
          nb = rd_hdr.prev;
        end else begin
          nf = rd_hdr.prev;
        end
      end
      OP_RESTORE: begin
        if (!ok_q) begin
          status = ST_BAD_STATE;
        end else begin
          nf = item_q.mark_front;
          nb = item_q.mark_back;
        end
      end
      default: begin
        status = ST_BAD_STATE;
      end
    endcase

    ok_new = (nf <= cap_lim) && (nb <= cap_lim) && (nf <= nb);
    result.status = status;
    result.data_offset = data_off;
    result.front_offset = nf;
    result.back_offset = nb;
    result.bytes_free = ok_new ? (nb - nf) : '0;
    cur_next.front = nf;
    cur_next.back = nb;
    hdr_wr_slot = d_ext[SLOT_W+2:3];
    hdr_wr_data.prev = is_back ? back : front;
    hdr_wr_data.size = item_q.size;
  end

endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Double-ended stack allocator unit testbench
// Drives allocate, free, reset and restore requests through the valid/ready
// input channel with random gaps, stalls the response channel at random, and
// checks every response field against a cursor and header tracker that is
// updated as each request is accepted. The capacity register is rewritten
// between phases while no response is outstanding, including values of zero
// and above the largest supported region.
// ----------------------------------------------------------------------------
module testbench;
  import dsa_pkg::*;

  localparam int unsigned HDR_SLOTS = MAX_CAPACITY_DEF / 8;
  localparam int unsigned ITEMS_PER_PHASE = 156;
  localparam int unsigned PHASES = 8;

  class cursor_tracker;
    logic [16:0] capacity;
    logic [16:0] front_cur;
    logic [16:0] back_cur;
    hdr_t        headers[HDR_SLOTS];
    out_item_t   pending_responses[$];
    int unsigned errors;

    function new();
      capacity = 17'(MAX_CAPACITY_DEF);
      front_cur = '0;
      back_cur = 17'(MAX_CAPACITY_DEF);
      foreach (headers[i]) headers[i] = '0;
      errors = 0;
    endfunction

    function longint unsigned cap_limit();
      if (capacity > MAX_CAPACITY_DEF) return MAX_CAPACITY_DEF;
      return capacity;
    endfunction

    function bit cursors_sane();
      return front_cur <= cap_limit() && back_cur <= cap_limit() && front_cur <= back_cur;
    endfunction

    function status_t allocate(in_item_t req, output longint unsigned data_off);
      longint unsigned algn, cur, payload, mis, pad, need;
      bit from_back;
      from_back = (req.side == SIDE_BACK);
      data_off = 0;
      algn = 64'd1 << req.align_log2;
      if (algn < MIN_ALIGN) algn = MIN_ALIGN;
      if (from_back && req.size == 0) return ST_ZERO_BACK;
      cur = from_back ? back_cur : front_cur;
      payload = from_back ? longint'(req.size) : longint'(HEADER_BYTES);
      mis = cur & (algn - 1);
      pad = 0;
      if (mis != 0) pad = from_back ? mis : algn - mis;
      if (pad < payload) pad += algn * ((payload - pad + algn - 1) / algn);
      need = front_cur + pad + (from_back ? longint'(HEADER_BYTES) : longint'(req.size));
      if (!(need < back_cur)) return ST_NO_SPACE;
      data_off = from_back ? cur - pad : cur + pad;
      headers[(data_off >> 3) % HDR_SLOTS].prev = cur[16:0];
      headers[(data_off >> 3) % HDR_SLOTS].size = req.size;
      if (from_back) back_cur = 17'(data_off - HEADER_BYTES);
      else front_cur = 17'(data_off + req.size);
      return ST_OK;
    endfunction

    function status_t free_block(in_item_t req);
      longint unsigned a;
      hdr_t h;
      a = req.addr;
      if (a < HEADER_BYTES || a >= cap_limit()) return ST_FREE_IGNORED;
      h = headers[(a >> 3) % HDR_SLOTS];
      if (req.side == SIDE_BACK) begin
        if (a < back_cur || a - HEADER_BYTES != back_cur) return ST_FREE_IGNORED;
        back_cur = h.prev;
      end else begin
        if (a >= front_cur || a + h.size != front_cur) return ST_FREE_IGNORED;
        front_cur = h.prev;
      end
      return ST_OK;
    endfunction

    function out_item_t apply_request(in_item_t req);
      out_item_t res;
      longint unsigned data_off;
      status_t st;
      data_off = 0;
      st = ST_OK;
      if (req.op == OP_RESET) begin
        front_cur = '0;
        back_cur = 17'(cap_limit());
      end else if (!cursors_sane()) begin
        st = ST_BAD_STATE;
      end else if (req.op == OP_ALLOC) begin
        st = allocate(req, data_off);
      end else if (req.op == OP_FREE) begin
        st = free_block(req);
      end else begin
        front_cur = req.mark_front;
        back_cur = req.mark_back;
      end
      res.status = st;
      res.data_offset = (st == ST_OK) ? 17'(data_off) : '0;
      res.front_offset = front_cur;
      res.back_offset = back_cur;
      res.bytes_free = cursors_sane() ? 17'(back_cur - front_cur) : '0;
      pending_responses.insert(pending_responses.size(), res);
      return res;
    endfunction

    task report_mismatch(string msg);
      errors++;
      if (errors <= 100) $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    task compare_response(out_item_t got);
      out_item_t want;
      if (pending_responses.size() == 0) begin
        report_mismatch($sformatf("response with no request outstanding, status %0d",
                                  got.status));
        return;
      end
      want = pending_responses[0];
      pending_responses.delete(0);
      if (got.status !== want.status)
        report_mismatch($sformatf("status %0d, want %0d", got.status, want.status));
      if (got.data_offset !== want.data_offset)
        report_mismatch($sformatf("data_offset %0d, want %0d",
                                  got.data_offset, want.data_offset));
      if (got.front_offset !== want.front_offset)
        report_mismatch($sformatf("front_offset %0d, want %0d",
                                  got.front_offset, want.front_offset));
      if (got.back_offset !== want.back_offset)
        report_mismatch($sformatf("back_offset %0d, want %0d",
                                  got.back_offset, want.back_offset));
      if (got.bytes_free !== want.bytes_free)
        report_mismatch($sformatf("bytes_free %0d, want %0d",
                                  got.bytes_free, want.bytes_free));
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [16:0] cfg_data = '0;

  cursor_tracker tracker;
  bit            steady = 1'b0;
  int unsigned   front_blocks[$];
  int unsigned   back_blocks[$];
  bit            mark_saved = 1'b0;
  logic [16:0]   mark_f, mark_b;
  int unsigned   mark_depth_f, mark_depth_b;

  double_ended_stack_allocator_unit dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_ready <= steady || ($urandom_range(0, 99) >= 38);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) tracker.compare_response(out_data);
  end

  function automatic in_item_t make_req(op_t op, logic side, logic [16:0] size,
                                        logic [3:0] align_log2, logic [15:0] addr,
                                        logic [16:0] mark_front, logic [16:0] mark_back);
    in_item_t req;
    req.op = op;
    req.side = side;
    req.size = size;
    req.align_log2 = align_log2;
    req.addr = addr;
    req.mark_front = mark_front;
    req.mark_back = mark_back;
    return req;
  endfunction

  function automatic logic [15:0] stack_top(logic side);
    if (side == SIDE_BACK) return (back_blocks.size() != 0) ? 16'(back_blocks[$]) : '0;
    return (front_blocks.size() != 0) ? 16'(front_blocks[$]) : '0;
  endfunction

  function automatic logic [16:0] pick_size();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 17'($urandom_range(0, 64));
    if (r < 90) return 17'($urandom_range(0, 1024));
    if (r < 97) return 17'($urandom_range(0, 16384));
    if (r < 98) return 17'(MAX_CAPACITY_DEF);
    return 17'($urandom_range(0, CUR_MAX));
  endfunction

  function automatic in_item_t random_request();
    in_item_t req;
    int unsigned r;
    longint unsigned lim;
    req = make_req(op_t'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                   17'($urandom_range(0, CUR_MAX)), 4'($urandom_range(0, 15)),
                   16'($urandom_range(0, 65535)), 17'($urandom_range(0, CUR_MAX)),
                   17'($urandom_range(0, CUR_MAX)));
    if ($urandom_range(0, 99) >= 85) return req;
    lim = tracker.cap_limit();
    r = $urandom_range(0, 99);
    if (r < 45) begin
      req.op = OP_ALLOC;
      req.size = pick_size();
      req.align_log2 = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(13, 15))
                                                   : 4'($urandom_range(0, 12));
    end else if (r < 80) begin
      req.op = OP_FREE;
      if (req.side == SIDE_FRONT && front_blocks.size() == 0 && back_blocks.size() != 0)
        req.side = SIDE_BACK;
      else if (req.side == SIDE_BACK && back_blocks.size() == 0 && front_blocks.size() != 0)
        req.side = SIDE_FRONT;
      if (front_blocks.size() == 0 && back_blocks.size() == 0)
        req.addr = 16'($urandom_range(0, (lim > 0) ? int'(lim - 1) : 0) & ~7);
      else
        req.addr = stack_top(req.side) + (($urandom_range(0, 11) == 0) ? 16'd8 : 16'd0);
    end else if (r < 90) begin
      req.op = OP_RESTORE;
      if (mark_saved && $urandom_range(0, 3) != 0) begin
        req.mark_front = mark_f;
        req.mark_back = mark_b;
      end else begin
        req.mark_front = 17'($urandom_range(0, int'(lim)));
        req.mark_back = 17'($urandom_range(0, int'(lim)));
      end
    end else begin
      req.op = OP_RESET;
    end
    return req;
  endfunction

  task automatic send_request(in_item_t req);
    out_item_t pred;
    while (!steady && $urandom_range(0, 99) < 38) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= req;
    do @(posedge clk); while (!in_ready);
    pred = tracker.apply_request(req);
    if (req.op == OP_RESET) begin
      front_blocks.delete();
      back_blocks.delete();
      mark_saved = 1'b0;
    end else if (pred.status == ST_OK && req.op == OP_ALLOC) begin
      if (req.side == SIDE_BACK) back_blocks.insert(back_blocks.size(), pred.data_offset);
      else front_blocks.insert(front_blocks.size(), pred.data_offset);
    end else if (pred.status == ST_OK && req.op == OP_FREE) begin
      if (req.side == SIDE_BACK) back_blocks.delete(back_blocks.size() - 1);
      else front_blocks.delete(front_blocks.size() - 1);
    end else if (pred.status == ST_OK && req.op == OP_RESTORE) begin
      if (mark_saved && req.mark_front == mark_f && req.mark_back == mark_b) begin
        while (front_blocks.size() > mark_depth_f)
          front_blocks.delete(front_blocks.size() - 1);
        while (back_blocks.size() > mark_depth_b)
          back_blocks.delete(back_blocks.size() - 1);
      end else begin
        front_blocks.delete();
        back_blocks.delete();
        mark_saved = 1'b0;
      end
    end
    if (tracker.cursors_sane() && $urandom_range(0, 19) == 0) begin
      mark_saved = 1'b1;
      mark_f = pred.front_offset;
      mark_b = pred.back_offset;
      mark_depth_f = front_blocks.size();
      mark_depth_b = back_blocks.size();
    end
  endtask

  task automatic drain_responses(int unsigned limit);
    int unsigned n;
    for (n = 0; n < limit && tracker.pending_responses.size() != 0; n++) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_capacity(logic [16:0] value);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    tracker.capacity = value;
  endtask

  initial begin
    #2_000_000;
    $display("testbench NOT OK");
    $finish;
  end

  initial begin
    logic [16:0] caps[PHASES];
    int unsigned p, i;
    tracker = new();
    caps = '{17'd65536, 17'd256, 17'd0, 17'd131071, 17'd4096, 17'd100, 17'd65535, 17'd0};
    caps[PHASES - 1] = 17'($urandom_range(0, CUR_MAX));
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    write_capacity(caps[0]);

    send_request(make_req(OP_ALLOC, SIDE_FRONT, 17'd0, 4'd0, '0, '0, '0));
    send_request(make_req(OP_ALLOC, SIDE_BACK, 17'd0, 4'd0, '0, '0, '0));
    send_request(make_req(OP_ALLOC, SIDE_FRONT, 17'd65536, 4'd3, '0, '0, '0));
    send_request(make_req(OP_ALLOC, SIDE_BACK, 17'd100, 4'd12, '0, '0, '0));
    send_request(make_req(OP_ALLOC, SIDE_FRONT, 17'd24, 4'd15, '0, '0, '0));
    send_request(make_req(OP_ALLOC, SIDE_BACK, 17'd8, 4'd0, '0, '0, '0));
    send_request(make_req(OP_FREE, SIDE_FRONT, '0, '0, stack_top(SIDE_FRONT) + 16'd8,
                          '0, '0));
    send_request(make_req(OP_FREE, SIDE_FRONT, '0, '0, stack_top(SIDE_FRONT), '0, '0));
    send_request(make_req(OP_FREE, SIDE_BACK, '0, '0, stack_top(SIDE_BACK), '0, '0));
    send_request(make_req(OP_FREE, SIDE_BACK, '0, '0, stack_top(SIDE_BACK), '0, '0));
    send_request(make_req(OP_FREE, SIDE_FRONT, '0, '0, stack_top(SIDE_FRONT), '0, '0));
    send_request(make_req(OP_FREE, SIDE_FRONT, '0, '0, 16'd0, '0, '0));
    send_request(make_req(OP_FREE, SIDE_BACK, '0, '0, 16'hFFFF, '0, '0));
    send_request(make_req(OP_RESTORE, SIDE_FRONT, '0, '0, '0, 17'd0, 17'd48));
    send_request(make_req(OP_ALLOC, SIDE_FRONT, 17'd32, 4'd3, '0, '0, '0));
    send_request(make_req(OP_ALLOC, SIDE_FRONT, 17'd31, 4'd3, '0, '0, '0));
    send_request(make_req(OP_RESTORE, SIDE_FRONT, '0, '0, '0, 17'd100, 17'd40));
    send_request(make_req(OP_ALLOC, SIDE_FRONT, 17'd8, 4'd0, '0, '0, '0));
    send_request(make_req(OP_FREE, SIDE_BACK, '0, '0, 16'd48, '0, '0));
    send_request(make_req(OP_RESTORE, SIDE_BACK, '0, '0, '0, 17'd0, 17'd64));
    send_request(make_req(OP_RESET, SIDE_BACK, 17'h1FFFF, 4'hF, 16'hFFFF, 17'h1FFFF,
                          17'h1FFFF));
    send_request(make_req(OP_RESTORE, SIDE_FRONT, '0, '0, '0, 17'd0, 17'h1FFFF));
    send_request(make_req(OP_RESET, SIDE_FRONT, '0, '0, '0, '0, '0));
    send_request(make_req(OP_RESTORE, SIDE_FRONT, '0, '0, '0, 17'd65536, 17'd65536));
    send_request(make_req(OP_ALLOC, SIDE_BACK, 17'd1, 4'd0, '0, '0, '0));
    send_request(make_req(OP_RESET, SIDE_FRONT, '0, '0, '0, '0, '0));

    for (p = 0; p < PHASES; p++) begin
      if (p != 0) begin
        in_valid <= 1'b0;
        drain_responses(20000);
        write_capacity(caps[p]);
        if ($urandom_range(0, 3) != 0)
          send_request(make_req(OP_RESET, SIDE_FRONT, '0, '0, '0, '0, '0));
      end
      steady = (p == 3);
      for (i = 0; i < ITEMS_PER_PHASE; i++) send_request(random_request());
    end
    in_valid <= 1'b0;
    steady = 1'b0;
    drain_responses(20000);
    if (tracker.pending_responses.size() != 0)
      tracker.report_mismatch($sformatf("%0d responses never arrived",
                                        tracker.pending_responses.size()));
    if (tracker.errors == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+src
src/dsa_pkg.sv
src/dsa_hdr_mem.sv
src/dsa_core.sv
src/double_ended_stack_allocator_unit.sv
dv/testbench.sv
